[design/snws_pkg.sv]
package snws_pkg;

	localparam int PAGE_BYTES_DEF   = 256;
	localparam int SECTOR_BYTES_DEF = 4096;
	localparam int ADDRESS_BITS_DEF = 24;
	localparam int ADDR_W           = 24;

	localparam logic [1:0] ACT_SELECT_SEND = 2'd0;
	localparam logic [1:0] ACT_SEND        = 2'd1;
	localparam logic [1:0] ACT_DESELECT    = 2'd2;
	localparam logic [1:0] ACT_WAIT        = 2'd3;

	localparam logic [1:0] REG_WRITE_ENABLE = 2'd0;
	localparam logic [1:0] REG_PAGE_PROGRAM = 2'd1;
	localparam logic [1:0] REG_SECTOR_ERASE = 2'd2;
	localparam logic [1:0] REG_STATUS_READ  = 2'd3;

	localparam logic [7:0] WRITE_ENABLE_RST = 8'd6;
	localparam logic [7:0] PAGE_PROGRAM_RST = 8'd2;
	localparam logic [7:0] SECTOR_ERASE_RST = 8'd32;
	localparam logic [7:0] STATUS_READ_RST  = 8'd5;

	typedef struct packed {
		logic              first_of_write;
		logic              last_of_write;
		logic [ADDR_W-1:0] start_address;
		logic [7:0]        data_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] spi_byte;
		logic       last_of_run;
	} res_t;

	typedef struct packed {
		logic [7:0] write_enable_opcode;
		logic [7:0] page_program_opcode;
		logic [7:0] sector_erase_opcode;
		logic [7:0] status_read_opcode;
	} cfg_t;

	// one classified byte: which command groups the back end must run
	typedef struct packed {
		logic              pre_close;
		logic              erase;
		logic              open_prog;
		logic              close_after;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} job_t;

endpackage

[design/spi_nor_write_sequencer.sv]
// Channel   Handshake             Payload     Beat when
// input     push / full           item_t      push && !full
// result    empty / pop           res_t       pop && !empty
// config    psel penable pwrite   32-bit APB  access phase, pready tied high
//
// The front end classifies one byte a cycle into a two-entry job queue until full.
// The back end emits one SPI action per cycle while a job waits and the result queue
// has room: only the data send inside an open frame, or close, erase, reopen, send, close.
// A two-entry result queue absorbs two beats while pop is low; once it is
// full the back end holds, and once the job queue is full too, full rises.
// Reset clears address, frame state, queues and restores the opcodes.
module spi_nor_write_sequencer import snws_pkg::*; #(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	output logic        empty,
	input  logic        pop,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;
	job_t job_in;
	job_t job_out;
	res_t res_in;
	logic job_empty;
	logic job_pop;
	logic res_full;
	logic res_push;
	logic accept;

	assign pready = 1'b1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_enable_opcode <= WRITE_ENABLE_RST;
			cfg_q.page_program_opcode <= PAGE_PROGRAM_RST;
			cfg_q.sector_erase_opcode <= SECTOR_ERASE_RST;
			cfg_q.status_read_opcode  <= STATUS_READ_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_WRITE_ENABLE: cfg_q.write_enable_opcode <= pwdata[7:0];
				REG_PAGE_PROGRAM: cfg_q.page_program_opcode <= pwdata[7:0];
				REG_SECTOR_ERASE: cfg_q.sector_erase_opcode <= pwdata[7:0];
				REG_STATUS_READ:  cfg_q.status_read_opcode  <= pwdata[7:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WRITE_ENABLE: prdata = {24'd0, cfg_q.write_enable_opcode};
			REG_PAGE_PROGRAM: prdata = {24'd0, cfg_q.page_program_opcode};
			REG_SECTOR_ERASE: prdata = {24'd0, cfg_q.sector_erase_opcode};
			REG_STATUS_READ:  prdata = {24'd0, cfg_q.status_read_opcode};
			default:          prdata = 32'd0;
		endcase
	end

	snws_front #(
		.PAGE_BYTES  (PAGE_BYTES),
		.SECTOR_BYTES(SECTOR_BYTES),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.job   (job_in)
	);

	snws_fifo #(
		.WIDTH($bits(job_t))
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   (job_in),
		.pop   (job_pop),
		.empty (job_empty),
		.dout  (job_out)
	);

	snws_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job      (job_out),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.res      (res_in),
		.res_full (res_full),
		.res_push (res_push)
	);

	snws_fifo #(
		.WIDTH($bits(res_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   (res_in),
		.pop   (pop),
		.empty (empty),
		.dout  (result)
	);

`ifndef SYNTHESIS
	// deselect and wait carry no byte
	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.action == ACT_DESELECT || result.action == ACT_WAIT)
		|-> result.spi_byte == 8'd0)
		else $error("deselect or wait carries a nonzero byte");

	// every close is a deselect followed by a wait, so a deselect never ends a run
	a_desel_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.action == ACT_DESELECT |-> !result.last_of_run)
		else $error("run ends on a deselect");

	// a run never ends on an opcode beat
	a_select_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.action == ACT_SELECT_SEND |-> !result.last_of_run)
		else $error("run ends on a select and send");

	// the sequencer only emits into a result queue with room
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");
`endif

endmodule

[design/snws_fifo.sv]
module snws_fifo import snws_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/snws_front.sv]
module snws_front import snws_pkg::*; #(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	output job_t  job
);

	// page and sector sizes are powers of two
	localparam logic [ADDRESS_BITS-1:0] PAGE_MASK = ADDRESS_BITS'(PAGE_BYTES - 1);
	localparam logic [ADDRESS_BITS-1:0] SEC_MASK  = ADDRESS_BITS'(SECTOR_BYTES - 1);

	logic [ADDRESS_BITS-1:0] cur_addr_q;
	logic                    frame_open_q;
	logic [ADDRESS_BITS-1:0] addr;
	logic [ADDRESS_BITS-1:0] next_addr;
	logic                    erase;
	logic                    close_after;

	assign addr        = item.first_of_write ? item.start_address[ADDRESS_BITS-1:0] : cur_addr_q;
	assign erase       = ((addr & SEC_MASK) == '0);
	assign next_addr   = addr + 1'b1;
	assign close_after = item.last_of_write || ((next_addr & PAGE_MASK) == '0);

	always_comb begin
		job.pre_close   = frame_open_q && (item.first_of_write || erase);
		job.erase       = erase;
		job.open_prog   = erase || item.first_of_write || !frame_open_q;
		job.close_after = close_after;
		job.addr        = ADDR_W'(addr);
		job.data        = item.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q   <= '0;
			frame_open_q <= 1'b0;
		end else if (accept) begin
			cur_addr_q   <= next_addr;
			frame_open_q <= !close_after;
		end
	end

endmodule

[design/snws_back.sv]
module snws_back import snws_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  job_t job,
	input  logic job_empty,
	output logic job_pop,
	output res_t res,
	input  logic res_full,
	output logic res_push
);

	localparam logic [2:0] SEG_PRE   = 3'd0;
	localparam logic [2:0] SEG_ERASE = 3'd1;
	localparam logic [2:0] SEG_OPEN  = 3'd2;
	localparam logic [2:0] SEG_DATA  = 3'd3;
	localparam logic [2:0] SEG_CLOSE = 3'd4;

	logic       active_q;
	logic [2:0] seg_q;
	logic [2:0] off_q;
	logic [2:0] start_seg;
	logic [2:0] cur_seg;
	logic [2:0] cur_off;
	logic [2:0] nxt_seg;
	logic       seg_end;
	logic       fin;
	logic       step;
	logic [1:0] act;
	logic [7:0] sbyte;

	always_comb begin
		priority if (job.pre_close) begin
			start_seg = SEG_PRE;
		end else if (job.erase) begin
			start_seg = SEG_ERASE;
		end else if (job.open_prog) begin
			start_seg = SEG_OPEN;
		end else begin
			start_seg = SEG_DATA;
		end
	end

	assign cur_seg = active_q ? seg_q : start_seg;
	assign cur_off = active_q ? off_q : 3'd0;

	always_comb begin
		act     = ACT_WAIT;
		sbyte   = 8'd0;
		seg_end = 1'b0;
		nxt_seg = SEG_DATA;
		fin     = 1'b0;
		unique case (cur_seg)
			SEG_PRE: begin
				act     = (cur_off == 3'd0) ? ACT_DESELECT : ACT_WAIT;
				seg_end = (cur_off == 3'd1);
				nxt_seg = job.erase ? SEG_ERASE : (job.open_prog ? SEG_OPEN : SEG_DATA);
			end
			SEG_ERASE: begin
				seg_end = (cur_off == 3'd7);
				nxt_seg = SEG_OPEN;
				unique case (cur_off)
					3'd0: begin act = ACT_SELECT_SEND; sbyte = cfg.write_enable_opcode; end
					3'd1: act = ACT_DESELECT;
					3'd2: begin act = ACT_SELECT_SEND; sbyte = cfg.sector_erase_opcode; end
					3'd3: begin act = ACT_SEND; sbyte = job.addr[23:16]; end
					3'd4: begin act = ACT_SEND; sbyte = job.addr[15:8]; end
					3'd5: begin act = ACT_SEND; sbyte = job.addr[7:0]; end
					3'd6: act = ACT_DESELECT;
					3'd7: act = ACT_WAIT;
					default: act = ACT_WAIT;
				endcase
			end
			SEG_OPEN: begin
				seg_end = (cur_off == 3'd5);
				nxt_seg = SEG_DATA;
				unique case (cur_off)
					3'd0: begin act = ACT_SELECT_SEND; sbyte = cfg.write_enable_opcode; end
					3'd1: act = ACT_DESELECT;
					3'd2: begin act = ACT_SELECT_SEND; sbyte = cfg.page_program_opcode; end
					3'd3: begin act = ACT_SEND; sbyte = job.addr[23:16]; end
					3'd4: begin act = ACT_SEND; sbyte = job.addr[15:8]; end
					3'd5: begin act = ACT_SEND; sbyte = job.addr[7:0]; end
					default: act = ACT_WAIT;
				endcase
			end
			SEG_DATA: begin
				act     = ACT_SEND;
				sbyte   = job.data;
				seg_end = 1'b1;
				nxt_seg = SEG_CLOSE;
				fin     = !job.close_after;
			end
			SEG_CLOSE: begin
				act     = (cur_off == 3'd0) ? ACT_DESELECT : ACT_WAIT;
				seg_end = (cur_off == 3'd1);
				fin     = (cur_off == 3'd1);
			end
			default: begin
				act = ACT_WAIT;
				fin = 1'b1;
			end
		endcase
	end

	assign step     = !job_empty && !res_full;
	assign res_push = step;
	assign job_pop  = step && fin;

	always_comb begin
		res.action      = act;
		res.spi_byte    = sbyte;
		res.last_of_run = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			seg_q    <= SEG_PRE;
			off_q    <= 3'd0;
		end else if (step) begin
			priority if (fin) begin
				active_q <= 1'b0;
			end else if (seg_end) begin
				active_q <= 1'b1;
				seg_q    <= nxt_seg;
				off_q    <= 3'd0;
			end else begin
				active_q <= 1'b1;
				seg_q    <= cur_seg;
				off_q    <= cur_off + 3'd1;
			end
		end
	end

endmodule
